// ----- sv/lal_pkg.sv -----
// ----------------------------------------------------------------------------
// lal_pkg
// Shared types, constants and helper functions of the ADR link adapter.
// ----------------------------------------------------------------------------
package lal_pkg;

   // default sizing
   localparam int HISTORY_DEPTH_DEF = 128;
   localparam int MAX_GATEWAYS_DEF  = 32;
   localparam int MIN_SF_DEF        = 7;

   // fixed field widths
   localparam int RX_W    = 13;
   localparam int SNR_W   = 14;
   localparam int THR_W   = 10;
   localparam int SF_W    = 4;
   localparam int PWR_W   = 5;
   localparam int DR_W    = 3;
   localparam int PIDX_W  = 3;
   localparam int STAT_W  = 2;
   localparam int MARG_W  = 15;
   localparam int STEP_W  = 10;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 60;

   // one 3 dB step in 1/16 dB
   localparam int STEP_DB = 48;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SNR_THR    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SNR_OFFSET = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GW_COMB    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIST_COMB  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HIST_RANGE = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TOGGLE_PWR = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_PWR    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PWR    = 4'd7;

   // combine codes
   localparam logic [1:0] COMB_MAX = 2'd1;
   localparam logic [1:0] COMB_MIN = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_NO_ADR    = 2'd0;
   localparam logic [STAT_W-1:0] ST_SHORT     = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNCHANGED = 2'd2;
   localparam logic [STAT_W-1:0] ST_ISSUED    = 2'd3;

   // reset values
   localparam logic [12:0] OFFSET_RST = 13'd1872;

   // spreading factor to data rate
   function automatic logic [DR_W-1:0] sf_to_dr(input logic [SF_W-1:0] sf);
      logic [DR_W-1:0] dr;
      if (sf >= 4'd8 && sf <= 4'd12) begin
         dr = DR_W'(4'd12 - sf);
      end else begin
         dr = 3'd5;
      end
      return dr;
   endfunction

   // link request power index
   function automatic logic [PIDX_W-1:0] power_index(input logic [PWR_W-1:0] p);
      logic [PIDX_W-1:0] idx;
      if (p >= 5'd16)      idx = 3'd0;
      else if (p >= 5'd14) idx = 3'd1;
      else if (p >= 5'd12) idx = 3'd2;
      else if (p >= 5'd10) idx = 3'd3;
      else if (p >= 5'd8)  idx = 3'd4;
      else if (p >= 5'd6)  idx = 3'd5;
      else if (p >= 5'd4)  idx = 3'd6;
      else                 idx = 3'd7;
      return idx;
   endfunction

   // required snr of a data rate
   function automatic logic signed [THR_W-1:0] thr_sel(input logic [CSR_DAT_W-1:0] thr,
                                                       input logic [DR_W-1:0] dr);
      logic signed [THR_W-1:0] t;
      case (dr)
         3'd0:    t = thr[9:0];
         3'd1:    t = thr[19:10];
         3'd2:    t = thr[29:20];
         3'd3:    t = thr[39:30];
         3'd4:    t = thr[49:40];
         default: t = thr[59:50];
      endcase
      return t;
   endfunction

endpackage

// ----- sv/lal_floor_div.sv -----
// ----------------------------------------------------------------------------
// lal_floor_div
// Shared bit-serial divider: signed dividend by positive divisor, quotient
// rounded toward minus infinity, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lal_floor_div
   import lal_pkg::*;
#(
   parameter int DW = 24,
   parameter int VW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] dividend,
   input  logic [VW-1:0]        divisor,
   output logic                 done,
   output logic signed [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW:0]      rem_ff, rem_in;
   logic [VW-1:0]    dsr_ff, dsr_in;
   logic             neg_ff, neg_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VW+1:0]    trial;
   logic [VW:0]      shifted;

   // a negative dividend is complemented (-a-1), divided, and complemented back
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      shifted = {rem_ff[VW-1:0], quo_ff[DW-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      if (start) begin
         neg_in  = dividend[DW-1];
         quo_in  = dividend[DW-1] ? ~dividend : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!trial[VW+1]) begin
            rem_in = trial[VW:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? ~quo_ff : quo_ff;

endmodule

// ----- sv/lorawan_adr_link_adapter.sv -----
// ----------------------------------------------------------------------------
// lorawan_adr_link_adapter
// LoRaWAN adaptive data rate decision from gateway receive powers.
// ----------------------------------------------------------------------------
// A record that is not the last gateway of a packet is taken with req_stall low.
// The last record starts a sequence that holds req_stall high: an average of
// gateways uses the shared divider, the history walk reads one entry per pass
// through the address and data states from the history memory, an average of
// history takes another divider pass, the 3 dB step count is formed in one
// state (a shift that divides by 16 and a reciprocal multiply by one third),
// and the step loop makes one spreading factor or power step per pass through
// its state. The result waits in an output register; the next record is
// taken meanwhile. The history memory has no reset; only entries already
// written are read.
module lorawan_adr_link_adapter
   import lal_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int MAX_GATEWAYS  = MAX_GATEWAYS_DEF,
   parameter int MIN_SF        = MIN_SF_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // gateway records
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [RX_W-1:0]   req_rx_power,
   input  logic                     req_last_gateway,
   input  logic                     req_adr_request,
   input  logic [SF_W-1:0]          req_spreading_factor,
   input  logic [PWR_W-1:0]         req_tx_power_dbm,
   // decisions
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [DR_W-1:0]          rsp_new_data_rate,
   output logic [PWR_W-1:0]         rsp_new_tx_power,
   output logic [PIDX_W-1:0]        rsp_tx_power_index,
   output logic signed [SNR_W-1:0]  rsp_packet_snr,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_data
);

   localparam int CW   = $clog2(MAX_GATEWAYS + 1);
   localparam int GSW  = RX_W + CW;
   localparam int AW   = $clog2(HISTORY_DEPTH);
   localparam int RW   = $clog2(HISTORY_DEPTH + 1);
   localparam int HSW  = SNR_W + RW;
   localparam int DW0  = (GSW > HSW) ? GSW : HSW;
   localparam int DW   = (DW0 > MARG_W) ? DW0 : MARG_W;
   localparam int VW0  = (CW > RW) ? CW : RW;
   localparam int VW   = (VW0 > 6) ? VW0 : 6;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_GW     = 11'b00000000010,
      S_GWWAIT = 11'b00000000100,
      S_PUSH   = 11'b00000001000,
      S_RADDR  = 11'b00000010000,
      S_RDATA  = 11'b00000100000,
      S_HCOMB  = 11'b00001000000,
      S_HWAIT  = 11'b00010000000,
      S_MARGIN = 11'b00100000000,
      S_STEP   = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [CSR_DAT_W-1:0]     thr_ff;
   logic signed [12:0]       offset_ff;
   logic [1:0]               gw_comb_ff, hist_comb_ff;
   logic [6:0]               hist_range_ff;
   logic                     toggle_ff;
   logic [PWR_W-1:0]         min_pwr_ff, max_pwr_ff;

   // gateway accumulation
   logic signed [GSW-1:0]    gsum_ff, gsum_in;
   logic signed [RX_W-1:0]   gbest_ff, gbest_in, gworst_ff, gworst_in;
   logic [CW-1:0]            gcnt_ff, gcnt_in;

   // packet context
   logic                     adr_ff, adr_in;
   logic [SF_W-1:0]          sf_ff, sf_in;
   logic [PWR_W-1:0]         tx_ff, tx_in;
   logic signed [RX_W-1:0]   power_ff, power_in;
   logic signed [SNR_W-1:0]  snr_ff, snr_in;

   // history
   logic [SNR_W-1:0]         hist_mem [HISTORY_DEPTH];
   logic [SNR_W-1:0]         rd_data_ff;
   logic [AW-1:0]            wp_ff, wp_in, rd_addr_ff, rd_addr_in;
   logic [RW-1:0]            fill_ff, fill_in, k_ff, k_in, range_eff, fill_next;
   logic                     mem_we;
   logic signed [HSW-1:0]    hsum_ff, hsum_in;
   logic signed [SNR_W-1:0]  hbest_ff, hbest_in, hworst_ff, hworst_in, hist_ff, hist_in;
   logic signed [SNR_W-1:0]  rd_val;

   // stepping
   logic signed [STEP_W-1:0] steps_ff, steps_in;
   logic [SF_W-1:0]          s_ff, s_in;
   logic signed [6:0]        p_ff, p_in;
   logic [PWR_W-1:0]         p_sat;
   logic [DR_W-1:0]          dr_now, ndr;
   logic [PWR_W-1:0]         ntx;

   // decision
   logic [STAT_W-1:0]        st_ff, st_in;
   logic [DR_W-1:0]          ndr_ff, ndr_in;
   logic [PWR_W-1:0]         ntx_ff, ntx_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        o_st_ff;
   logic [DR_W-1:0]          o_dr_ff;
   logic [PWR_W-1:0]         o_pwr_ff;
   logic signed [SNR_W-1:0]  o_snr_ff;
   logic                     out_load;

   // shared divider
   logic                     div_start, div_done;
   logic signed [DW-1:0]     div_a, div_q;
   logic [VW-1:0]            div_b;
   logic signed [MARG_W-1:0] margin;

   // step count
   logic [10:0]              m16;
   logic [9:0]               m16_mag;
   logic [19:0]              m16_prod;
   logic signed [STEP_W-1:0] steps_calc;

   logic                     req_take;
   logic                     gw_avg, hist_avg;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign gw_avg    = (gw_comb_ff != COMB_MAX) && (gw_comb_ff != COMB_MIN);
   assign hist_avg  = (hist_comb_ff != COMB_MAX) && (hist_comb_ff != COMB_MIN);
   assign dr_now    = sf_to_dr(sf_ff);
   assign rd_val    = rd_data_ff;
   assign margin    = MARG_W'(hist_ff) - MARG_W'(thr_sel(thr_ff, dr_now));

   // floor of margin / 48: floor by 16, then floor by 3 with a reciprocal multiply;
   // a negative value is complemented, divided and complemented back
   always_comb begin
      m16        = margin[MARG_W-1:4];
      m16_mag    = m16[10] ? ~m16[9:0] : m16[9:0];
      m16_prod   = m16_mag * 10'd683;
      steps_calc = m16[10] ? ~{1'b0, m16_prod[19:11]} : {1'b0, m16_prod[19:11]};
   end

   // effective history range
   always_comb begin
      if (hist_range_ff == 7'd0) begin
         range_eff = RW'(1);
      end else if (32'(hist_range_ff) > HISTORY_DEPTH) begin
         range_eff = RW'(HISTORY_DEPTH);
      end else begin
         range_eff = RW'(hist_range_ff);
      end
      fill_next = (fill_ff == RW'(HISTORY_DEPTH)) ? fill_ff : fill_ff + 1'b1;
   end

   // saturated power and step outcome
   always_comb begin
      if (p_ff < 7'sd0)       p_sat = '0;
      else if (p_ff > 7'sd31) p_sat = 5'd31;
      else                    p_sat = p_ff[PWR_W-1:0];
      ndr = sf_to_dr(s_ff);
      ntx = toggle_ff ? p_sat : tx_ff;
   end

   // divider operand selection
   always_comb begin
      div_start = 1'b0;
      div_a     = DW'(gsum_ff);
      div_b     = VW'(gcnt_ff);
      case (state_ff)
         S_GW: begin
            div_start = gw_avg;
         end
         S_HCOMB: begin
            div_start = hist_avg;
            div_a     = DW'(hsum_ff);
            div_b     = VW'(range_eff);
         end
         default: ;
      endcase
   end

   lal_floor_div #(
      .DW (DW),
      .VW (VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      gsum_in    = gsum_ff;
      gbest_in   = gbest_ff;
      gworst_in  = gworst_ff;
      gcnt_in    = gcnt_ff;
      adr_in     = adr_ff;
      sf_in      = sf_ff;
      tx_in      = tx_ff;
      power_in   = power_ff;
      snr_in     = snr_ff;
      wp_in      = wp_ff;
      rd_addr_in = rd_addr_ff;
      fill_in    = fill_ff;
      k_in       = k_ff;
      hsum_in    = hsum_ff;
      hbest_in   = hbest_ff;
      hworst_in  = hworst_ff;
      hist_in    = hist_ff;
      steps_in   = steps_ff;
      s_in       = s_ff;
      p_in       = p_ff;
      st_in      = st_ff;
      ndr_in     = ndr_ff;
      ntx_in     = ntx_ff;
      mem_we     = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (gcnt_ff < CW'(MAX_GATEWAYS)) begin
                  if (gcnt_ff == '0) begin
                     gsum_in   = GSW'(req_rx_power);
                     gbest_in  = req_rx_power;
                     gworst_in = req_rx_power;
                  end else begin
                     gsum_in = gsum_ff + GSW'(req_rx_power);
                     if (req_rx_power > gbest_ff)  gbest_in  = req_rx_power;
                     if (req_rx_power < gworst_ff) gworst_in = req_rx_power;
                  end
                  gcnt_in = gcnt_ff + 1'b1;
               end
               if (req_last_gateway) begin
                  adr_in   = req_adr_request;
                  sf_in    = req_spreading_factor;
                  tx_in    = req_tx_power_dbm;
                  state_in = S_GW;
               end
            end
         end
         S_GW: begin
            if (gw_comb_ff == COMB_MAX) power_in = gbest_ff;
            else if (gw_comb_ff == COMB_MIN) power_in = gworst_ff;
            gsum_in   = '0;
            gbest_in  = '0;
            gworst_in = '0;
            gcnt_in   = '0;
            state_in  = gw_avg ? S_GWWAIT : S_PUSH;
         end
         S_GWWAIT: begin
            if (div_done) begin
               power_in = div_q[RX_W-1:0];
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            snr_in     = SNR_W'(power_ff) + SNR_W'(offset_ff);
            mem_we     = 1'b1;
            rd_addr_in = wp_ff;
            wp_in      = (wp_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            fill_in    = fill_next;
            k_in       = '0;
            s_in       = sf_ff;
            p_in       = 7'($signed({2'b00, tx_ff}));
            ndr_in     = dr_now;
            ntx_in     = tx_ff;
            if (!adr_ff) begin
               st_in    = ST_NO_ADR;
               state_in = S_OUT;
            end else if (fill_next < range_eff) begin
               st_in    = ST_SHORT;
               state_in = S_OUT;
            end else begin
               state_in = S_RADDR;
            end
         end
         S_RADDR: begin
            state_in = S_RDATA;
         end
         S_RDATA: begin
            if (k_ff == '0) begin
               hsum_in   = HSW'(rd_val);
               hbest_in  = rd_val;
               hworst_in = rd_val;
            end else begin
               hsum_in = hsum_ff + HSW'(rd_val);
               if (rd_val > hbest_ff)  hbest_in  = rd_val;
               if (rd_val < hworst_ff) hworst_in = rd_val;
            end
            rd_addr_in = (rd_addr_ff == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_ff - 1'b1;
            k_in       = k_ff + 1'b1;
            state_in   = (k_ff + 1'b1 == range_eff) ? S_HCOMB : S_RADDR;
         end
         S_HCOMB: begin
            if (hist_comb_ff == COMB_MAX) hist_in = hbest_ff;
            else if (hist_comb_ff == COMB_MIN) hist_in = hworst_ff;
            state_in = hist_avg ? S_HWAIT : S_MARGIN;
         end
         S_HWAIT: begin
            if (div_done) begin
               hist_in  = div_q[SNR_W-1:0];
               state_in = S_MARGIN;
            end
         end
         S_MARGIN: begin
            steps_in = steps_calc;
            state_in = S_STEP;
         end
         S_STEP: begin
            // lower sf first, then power; negative steps raise power
            if (steps_ff > 0 && s_ff > SF_W'(MIN_SF)) begin
               s_in     = s_ff - 1'b1;
               steps_in = steps_ff - 1'b1;
            end else if (steps_ff > 0 && p_ff > 7'($signed({2'b00, min_pwr_ff}))) begin
               p_in     = p_ff - 7'sd2;
               steps_in = steps_ff - 1'b1;
            end else if (steps_ff < 0 && p_ff < 7'($signed({2'b00, max_pwr_ff}))) begin
               p_in     = p_ff + 7'sd2;
               steps_in = steps_ff + 1'b1;
            end else begin
               ndr_in   = ndr;
               ntx_in   = ntx;
               st_in    = (ndr != dr_now || ntx != tx_ff) ? ST_ISSUED : ST_UNCHANGED;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gsum_ff      <= '0;
         gbest_ff     <= '0;
         gworst_ff    <= '0;
         gcnt_ff      <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gsum_ff      <= gsum_in;
         gbest_ff     <= gbest_in;
         gworst_ff    <= gworst_in;
         gcnt_ff      <= gcnt_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      adr_ff     <= adr_in;
      sf_ff      <= sf_in;
      tx_ff      <= tx_in;
      power_ff   <= power_in;
      snr_ff     <= snr_in;
      rd_addr_ff <= rd_addr_in;
      k_ff       <= k_in;
      hsum_ff    <= hsum_in;
      hbest_ff   <= hbest_in;
      hworst_ff  <= hworst_in;
      hist_ff    <= hist_in;
      steps_ff   <= steps_in;
      s_ff       <= s_in;
      p_ff       <= p_in;
      st_ff      <= st_in;
      ndr_ff     <= ndr_in;
      ntx_ff     <= ntx_in;
      if (out_load) begin
         o_st_ff  <= st_ff;
         o_dr_ff  <= ndr_ff;
         o_pwr_ff <= ntx_ff;
         o_snr_ff <= snr_ff;
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wp_ff] <= SNR_W'(power_ff) + SNR_W'(offset_ff);
      end
      rd_data_ff <= hist_mem[rd_addr_ff];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= '0;
         offset_ff     <= OFFSET_RST;
         gw_comb_ff    <= '0;
         hist_comb_ff  <= '0;
         hist_range_ff <= 7'd4;
         toggle_ff     <= 1'b1;
         min_pwr_ff    <= 5'd2;
         max_pwr_ff    <= 5'd14;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SNR_THR:    thr_ff        <= csr_data;
            REG_SNR_OFFSET: offset_ff     <= csr_data[12:0];
            REG_GW_COMB:    gw_comb_ff    <= csr_data[1:0];
            REG_HIST_COMB:  hist_comb_ff  <= csr_data[1:0];
            REG_HIST_RANGE: hist_range_ff <= csr_data[6:0];
            REG_TOGGLE_PWR: toggle_ff     <= csr_data[0];
            REG_MIN_PWR:    min_pwr_ff    <= csr_data[4:0];
            REG_MAX_PWR:    max_pwr_ff    <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = o_st_ff;
   assign rsp_new_data_rate  = o_dr_ff;
   assign rsp_new_tx_power   = o_pwr_ff;
   assign rsp_tx_power_index = power_index(o_pwr_ff);
   assign rsp_packet_snr     = o_snr_ff;

endmodule

// ----- sv/lal_checker.sv -----
// ----------------------------------------------------------------------------
// lal_checker
// Port-level checks of the ADR link adapter, bound to the top level.
// ----------------------------------------------------------------------------
module lal_checker
   import lal_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_last_gateway,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [PWR_W-1:0]        rsp_new_tx_power,
   input logic [PIDX_W-1:0]       rsp_tx_power_index
);

   // a waiting result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // the last record of a packet makes the block busy
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_gateway |=> req_stall)
      else $error("last record did not start a decision");

   // power index agrees with the chosen power
   a_pidx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tx_power_index == power_index(rsp_new_tx_power))
      else $error("power index mismatch");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lorawan_adr_link_adapter lal_checker u_lal_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_last_gateway   (req_last_gateway),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_new_tx_power   (rsp_new_tx_power),
   .rsp_tx_power_index (rsp_tx_power_index)
);
